// ----- hdl/u8rx_pkg.sv -----
// Package with the request types and fixed constants of the 8N1 UART with receive buffer.
`default_nettype none

package u8rx_pkg;

  typedef struct packed {
    logic       rx_line;
    logic       write_req;
    logic [7:0] write_byte;
    logic       read_req;
  } in_req_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       write_taken;
    logic       rx_nonempty;
    logic [7:0] front_byte;
    logic [5:0] rx_level;
    logic       rx_dropped;
  } out_req_t;

  localparam logic [15:0] BIT_PERIOD_RST = 16'd104;
  localparam logic [3:0]  TX_FRAME_BITS  = 4'd10;
  localparam logic [3:0]  RX_DATA_BITS   = 4'd8;

endpackage

`default_nettype wire

// ----- hdl/uart_8n1_with_rx_fifo.sv -----
// Top level of the 8N1 UART with transmitter, receiver and receive ring buffer.
//
//   Channel  Direction  Handshake            Payload
//   in_      in         in_valid / in_stall  u8rx_pkg::in_req_t (one tick per request)
//   out_     out        out_valid / out_stall u8rx_pkg::out_req_t (one result per request)
//   cfg_     in         cfg_we               cfg_wdata, bit period in ticks
//
// Each accepted request is one timer tick; its result appears in the output register on the
// next cycle, so a new request can be taken every cycle unless a held result is stalled.
// The input stalls only while a finished result is held and the output side stalls.
// Reset is synchronous and active low; the buffer memory needs no clearing pass.
// The front byte is kept prefetched from the buffer memory so a pop never waits on a memory read.
`default_nettype none

module uart_8n1_with_rx_fifo #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic cfg_we,
  input  wire                logic [15:0] cfg_wdata,
  input  wire                logic in_valid,
  output                     logic in_stall,
  input  wire u8rx_pkg::in_req_t in_data,
  output                     logic out_valid,
  input  wire                logic out_stall,
  output     u8rx_pkg::out_req_t out_data
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LW = PW + 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_L  = LW'(FIFO_DEPTH);

  logic [15:0] bit_period_r;

  logic        tx_active_r, tx_active_nxt;
  logic [9:0]  tx_frame_r, tx_frame_nxt;
  logic [3:0]  tx_bits_left_r, tx_bits_left_nxt;
  logic [15:0] tx_ticks_r, tx_ticks_nxt;
  logic        tx_level_r, tx_level_nxt;

  logic        rx_prev_level_r;
  logic        rx_sampling_r, rx_sampling_nxt;
  logic [16:0] rx_ticks_r, rx_ticks_nxt;
  logic [3:0]  rx_bits_left_r, rx_bits_left_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;

  logic [7:0]    mem_r [FIFO_DEPTH];
  logic [7:0]    front_r;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] head_inc, tail_inc;
  logic          wr_en;
  logic [LW-1:0] level;

  logic                 out_valid_r;
  u8rx_pkg::out_req_t   out_data_r;
  u8rx_pkg::out_req_t   res;
  logic                 in_acc;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + PW'(1);
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + PW'(1);

  always_comb begin
    tx_active_nxt    = tx_active_r;
    tx_frame_nxt     = tx_frame_r;
    tx_bits_left_nxt = tx_bits_left_r;
    tx_ticks_nxt     = tx_ticks_r;
    tx_level_nxt     = tx_level_r;
    rx_sampling_nxt  = rx_sampling_r;
    rx_ticks_nxt     = rx_ticks_r;
    rx_bits_left_nxt = rx_bits_left_r;
    rx_shift_nxt     = rx_shift_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    wr_en            = 1'b0;
    res              = '0;

    if (tx_active_r) begin
      if (tx_ticks_r <= 16'd1) begin
        tx_level_nxt     = tx_frame_r[0];
        tx_frame_nxt     = {1'b0, tx_frame_r[9:1]};
        tx_bits_left_nxt = tx_bits_left_r - 4'd1;
        tx_ticks_nxt     = bit_period_r;
        if (tx_bits_left_nxt == 4'd0) begin
          tx_active_nxt    = 1'b0;
          tx_bits_left_nxt = u8rx_pkg::TX_FRAME_BITS;
        end
      end else begin
        tx_ticks_nxt = tx_ticks_r - 16'd1;
      end
    end else if (in_data.write_req) begin
      res.write_taken  = 1'b1;
      tx_active_nxt    = 1'b1;
      tx_frame_nxt     = {1'b1, in_data.write_byte, 1'b0};
      tx_bits_left_nxt = u8rx_pkg::TX_FRAME_BITS;
      tx_ticks_nxt     = bit_period_r;
      tx_level_nxt     = 1'b1;
    end

    res.rx_nonempty = (head_r != tail_r);
    if (res.rx_nonempty) begin
      res.front_byte = front_r;
      if (in_data.read_req) begin
        tail_nxt = tail_inc;
      end
    end

    if (!rx_sampling_r) begin
      if (rx_prev_level_r && !in_data.rx_line) begin
        rx_sampling_nxt  = 1'b1;
        rx_ticks_nxt     = {1'b0, bit_period_r} + {2'b00, bit_period_r[15:1]};
        rx_bits_left_nxt = u8rx_pkg::RX_DATA_BITS;
      end
    end else if (rx_ticks_r <= 17'd1) begin
      rx_shift_nxt     = {in_data.rx_line, rx_shift_r[7:1]};
      rx_bits_left_nxt = rx_bits_left_r - 4'd1;
      rx_ticks_nxt     = {1'b0, bit_period_r};
      if (rx_bits_left_nxt == 4'd0) begin
        if (head_inc != tail_nxt) begin
          wr_en    = 1'b1;
          head_nxt = head_inc;
        end else begin
          res.rx_dropped = 1'b1;
        end
        rx_bits_left_nxt = u8rx_pkg::RX_DATA_BITS;
        rx_sampling_nxt  = 1'b0;
      end
    end else begin
      rx_ticks_nxt = rx_ticks_r - 17'd1;
    end

    if (head_nxt >= tail_nxt) begin
      level = {1'b0, head_nxt} - {1'b0, tail_nxt};
    end else begin
      level = DEPTH_L + {1'b0, head_nxt} - {1'b0, tail_nxt};
    end

    res.tx_line  = tx_level_nxt;
    res.tx_busy  = tx_active_nxt;
    res.rx_level = 6'(level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r    <= u8rx_pkg::BIT_PERIOD_RST;
      tx_active_r     <= 1'b0;
      tx_frame_r      <= '0;
      tx_bits_left_r  <= u8rx_pkg::TX_FRAME_BITS;
      tx_ticks_r      <= '0;
      tx_level_r      <= 1'b1;
      rx_prev_level_r <= 1'b1;
      rx_sampling_r   <= 1'b0;
      rx_ticks_r      <= '0;
      rx_bits_left_r  <= u8rx_pkg::RX_DATA_BITS;
      rx_shift_r      <= '0;
      head_r          <= '0;
      tail_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        bit_period_r <= cfg_wdata;
      end
      if (in_acc) begin
        tx_active_r     <= tx_active_nxt;
        tx_frame_r      <= tx_frame_nxt;
        tx_bits_left_r  <= tx_bits_left_nxt;
        tx_ticks_r      <= tx_ticks_nxt;
        tx_level_r      <= tx_level_nxt;
        rx_prev_level_r <= in_data.rx_line;
        rx_sampling_r   <= rx_sampling_nxt;
        rx_ticks_r      <= rx_ticks_nxt;
        rx_bits_left_r  <= rx_bits_left_nxt;
        rx_shift_r      <= rx_shift_nxt;
        head_r          <= head_nxt;
        tail_r          <= tail_nxt;
        out_valid_r     <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

  // The front byte register always holds the entry at the tail pointer.
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      mem_r[head_r] <= rx_shift_nxt;
    end
    if (in_acc && wr_en && (head_r == tail_nxt)) begin
      front_r <= rx_shift_nxt;
    end else if (in_acc) begin
      front_r <= mem_r[tail_nxt];
    end else begin
      front_r <= mem_r[tail_r];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/u8rx_checker.sv -----
// Port-level checker for the 8N1 UART with receive buffer, bound to the top level.
`default_nettype none

module u8rx_checker (
  input wire                logic clk,
  input wire                logic rst_n,
  input wire                logic in_valid,
  input wire                logic in_stall,
  input wire                logic out_valid,
  input wire                logic out_stall,
  input wire u8rx_pkg::out_req_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was withdrawn.");

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted request produced no result.");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_taken |-> out_data.tx_busy && out_data.tx_line)
    else $error("Taken write did not start an idle-level busy period.");

  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.rx_nonempty |-> out_data.front_byte == 8'd0)
    else $error("Front byte nonzero while the buffer was empty.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result shown right after reset.");

endmodule

bind uart_8n1_with_rx_fifo u8rx_checker u_u8rx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- test/tb_u8rx_scoreboard_pkg.sv -----
// Scoreboard class that predicts and checks the per-tick results of the 8N1 UART with receive buffer.
`timescale 1ns / 1ps

package u8rx_tb_pkg;

  localparam int RX_DEPTH = 64;

  class uart_tick_scoreboard;
    bit [15:0] bit_period;
    bit        tx_active;
    bit [9:0]  tx_frame;
    bit [3:0]  tx_bits_left;
    bit [15:0] tx_ticks;
    bit        tx_level;
    bit        rx_prev;
    bit        rx_sampling;
    bit [16:0] rx_ticks;
    bit [3:0]  rx_bits_left;
    bit [7:0]  rx_shift;
    bit [7:0]  rx_store [RX_DEPTH];
    int        rx_head;
    int        rx_tail;
    u8rx_pkg::out_req_t expected_results [$];
    int        errors;

    function new();
      bit_period   = u8rx_pkg::BIT_PERIOD_RST;
      tx_active    = 1'b0;
      tx_frame     = '0;
      tx_bits_left = u8rx_pkg::TX_FRAME_BITS;
      tx_ticks     = '0;
      tx_level     = 1'b1;
      rx_prev      = 1'b1;
      rx_sampling  = 1'b0;
      rx_ticks     = '0;
      rx_bits_left = u8rx_pkg::RX_DATA_BITS;
      rx_shift     = '0;
      rx_head      = 0;
      rx_tail      = 0;
      errors       = 0;
      foreach (rx_store[i]) rx_store[i] = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(u8rx_pkg::in_req_t req);
      u8rx_pkg::out_req_t r;
      int       next_head;
      r = '0;

      if (tx_active) begin
        if (tx_ticks <= 16'd1) begin
          tx_level     = tx_frame[0];
          tx_frame     = tx_frame >> 1;
          tx_bits_left = tx_bits_left - 4'd1;
          tx_ticks     = bit_period;
          if (tx_bits_left == 4'd0) begin
            tx_active    = 1'b0;
            tx_bits_left = u8rx_pkg::TX_FRAME_BITS;
          end
        end else begin
          tx_ticks = tx_ticks - 16'd1;
        end
      end else if (req.write_req) begin
        r.write_taken = 1'b1;
        tx_active     = 1'b1;
        tx_frame      = {1'b1, req.write_byte, 1'b0};
        tx_bits_left  = u8rx_pkg::TX_FRAME_BITS;
        tx_ticks      = bit_period;
        tx_level      = 1'b1;
      end

      r.rx_nonempty = (rx_head != rx_tail);
      if (r.rx_nonempty) begin
        r.front_byte = rx_store[rx_tail];
        if (req.read_req) rx_tail = (rx_tail + 1) % RX_DEPTH;
      end

      if (!rx_sampling) begin
        if (rx_prev && !req.rx_line) begin
          rx_sampling  = 1'b1;
          rx_ticks     = 17'(bit_period) + 17'(bit_period >> 1);
          rx_bits_left = u8rx_pkg::RX_DATA_BITS;
        end
      end else if (rx_ticks <= 17'd1) begin
        rx_shift     = {req.rx_line, rx_shift[7:1]};
        rx_bits_left = rx_bits_left - 4'd1;
        rx_ticks     = 17'(bit_period);
        if (rx_bits_left == 4'd0) begin
          next_head = (rx_head + 1) % RX_DEPTH;
          if (next_head != rx_tail) begin
            rx_store[rx_head] = rx_shift;
            rx_head = next_head;
          end else begin
            r.rx_dropped = 1'b1;
          end
          rx_bits_left = u8rx_pkg::RX_DATA_BITS;
          rx_sampling  = 1'b0;
        end
      end else begin
        rx_ticks = rx_ticks - 17'd1;
      end
      rx_prev = req.rx_line;

      r.rx_level = 6'((rx_head + RX_DEPTH - rx_tail) % RX_DEPTH);
      r.tx_line  = tx_level;
      r.tx_busy  = tx_active;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(u8rx_pkg::out_req_t got);
      u8rx_pkg::out_req_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request pending, expected none, actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("tx_line", 8'(want.tx_line), 8'(got.tx_line));
      compare_field("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
      compare_field("write_taken", 8'(want.write_taken), 8'(got.write_taken));
      compare_field("rx_nonempty", 8'(want.rx_nonempty), 8'(got.rx_nonempty));
      compare_field("front_byte", want.front_byte, got.front_byte);
      compare_field("rx_level", 8'(want.rx_level), 8'(got.rx_level));
      compare_field("rx_dropped", 8'(want.rx_dropped), 8'(got.rx_dropped));
    endfunction
  endclass

endpackage

// ----- test/tb_uart_8n1_with_rx_fifo.sv -----
// Testbench top that drives serial frames, writes and reads into the UART and checks every result.
`timescale 1ns / 1ps

module tb_uart_8n1_with_rx_fifo;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  u8rx_pkg::in_req_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  u8rx_pkg::out_req_t out_data;

  u8rx_tb_pkg::uart_tick_scoreboard sb;
  int sent      = 0;
  int cycles    = 0;
  bit steady    = 1'b0;
  int read_pct  = 0;
  int write_pct = 0;

  uart_8n1_with_rx_fifo #(
    .FIFO_DEPTH(u8rx_tb_pkg::RX_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 22);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic u8rx_pkg::in_req_t make_req(logic rx, logic wr, logic [7:0] wbyte,
                                                 logic rd);
    u8rx_pkg::in_req_t req;
    req.rx_line    = rx;
    req.write_req  = wr;
    req.write_byte = wbyte;
    req.read_req   = rd;
    return req;
  endfunction

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_tick(input u8rx_pkg::in_req_t req);
    bit taken;
    int gap;
    gap = 0;
    steady = (sent >= 700) && (sent < 1000);
    if (!steady) begin
      while ($urandom_range(0, 99) < 22) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_request(req);
    sent++;
  endtask

  task automatic tick(input logic rx);
    send_tick(make_req(rx, $urandom_range(0, 99) < write_pct, 8'($urandom_range(0, 255)),
                       $urandom_range(0, 99) < read_pct));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_bit_period(input logic [15:0] period);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.bit_period = period;
  endtask

  task automatic serial_byte(input logic [7:0] data, input logic [15:0] period);
    logic [9:0] frame;
    frame = {1'b1, data, 1'b0};
    for (int i = 0; i < 10; i++) repeat (period) tick(frame[i]);
    repeat ($urandom_range(0, 3)) tick(1'b1);
  endtask

  task automatic run_phase(input logic [15:0] period, input int items, input int rd,
                           input int wr);
    int first;
    int kind;
    set_bit_period(period);
    read_pct  = rd;
    write_pct = wr;
    first     = sent;
    while (sent - first < items) begin
      kind = (period > 16'd16) ? 9 : $urandom_range(0, 9);
      if (kind < 7) begin
        serial_byte(pick_byte(), period);
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 6 * period)) tick(1'($urandom_range(0, 1)));
        repeat (2 * period) tick(1'b1);
      end else begin
        repeat ($urandom_range(1, 12)) tick(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(make_req(1'b1, 1'b1, 8'hFF, 1'b1));
    send_tick(make_req(1'b1, 1'b1, 8'h00, 1'b0));
    send_tick(make_req(1'b0, 1'b0, 8'hFF, 1'b0));
    send_tick(make_req(1'b1, 1'b0, 8'h00, 1'b1));
    send_tick(make_req(1'b0, 1'b1, 8'h5A, 1'b0));

    run_phase(16'd3, 80, 50, 30);
    run_phase(16'd2, 1300, 0, 40);
    run_phase(16'd2, 70, 2, 40);
    run_phase(16'd4, 80, 60, 20);
    run_phase(16'd7, 85, 30, 30);
    run_phase(16'd65535, 30, 50, 50);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
